// File: rtl/cfb_pkg.sv
// Package: shared types, constants and the CRC byte update for the frame builder.
`timescale 1ns / 1ps
package cfb_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned REM_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW = $clog2(Q_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_START_ONE = 2'd0;
  localparam logic [1:0] REG_START_TWO = 2'd1;
  localparam logic [1:0] REG_VERSION   = 2'd2;

  // job kinds passed from the front to the back
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  typedef struct packed {
    logic        command;
    logic [7:0]  frame_type;
    logic [15:0] sequence_number;
    logic [15:0] data_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       error;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_byte_one;
    logic [7:0] start_byte_two;
    logic [7:0] version_byte;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;       // frame closes with this job: append CRC
    logic [7:0]  frame_type;
    logic [15:0] seq;
    logic [15:0] len;
    logic [7:0]  data;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/cfb_front.sv
// Front end: takes input beats, tracks frame state and queues classified jobs.
`timescale 1ns / 1ps
module cfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfb_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output cfb_pkg::job_t     q_job
);
  import cfb_pkg::*;

  logic             frame_open_r, frame_open_nxt;
  logic [REM_W-1:0] remaining_r, remaining_nxt;
  logic             len_bad;

  assign q_push  = push && !q_full;
  assign len_bad = in_item.data_len > 16'(MAX_PAYLOAD);

  always_comb begin
    frame_open_nxt  = frame_open_r;
    remaining_nxt   = remaining_r;
    q_job.kind       = KIND_ERR;
    q_job.last       = 1'b0;
    q_job.frame_type = in_item.frame_type;
    q_job.seq        = in_item.sequence_number;
    q_job.len        = in_item.data_len;
    q_job.data       = in_item.data_byte;
    if (!in_item.command) begin
      // a start always drops whatever frame was open
      frame_open_nxt = 1'b0;
      remaining_nxt  = '0;
      if (!len_bad) begin
        q_job.kind = KIND_START;
        if (in_item.data_len == 16'd0) begin
          q_job.last = 1'b1;
        end else begin
          frame_open_nxt = 1'b1;
          remaining_nxt  = in_item.data_len[REM_W-1:0];
        end
      end
    end else if (frame_open_r && (remaining_r != '0)) begin
      q_job.kind    = KIND_DATA;
      remaining_nxt = remaining_r - REM_W'(1);
      if (remaining_r == REM_W'(1)) begin
        q_job.last     = 1'b1;
        frame_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      remaining_r  <= '0;
    end else if (q_push) begin
      frame_open_r <= frame_open_nxt;
      remaining_r  <= remaining_nxt;
    end
  end

endmodule

// File: rtl/cfb_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module cfb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  cfb_pkg::job_t wr_job,
  input  logic          rd_en,
  output cfb_pkg::job_t rd_job,
  output logic          q_full,
  output logic          q_empty
);
  import cfb_pkg::*;

  job_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign q_full  = count_r == (Q_AW + 1)'(Q_DEPTH);
  assign q_empty = count_r == '0;
  assign rd_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + (Q_AW + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - (Q_AW + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/cfb_back.sv
// Back end: walks each job beat by beat, runs the CRC and fills the output register.
`timescale 1ns / 1ps
module cfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cfb_pkg::cfg_t      cfg,
  input  cfb_pkg::job_t      job,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output cfb_pkg::out_item_t out_item
);
  import cfb_pkg::*;

  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        advance;
  logic [3:0]  last_step;
  out_item_t   beat;
  logic        covered;
  logic [15:0] crc_base;

  assign advance  = !q_empty && (!out_valid_r || pop);
  assign q_pop    = advance && (step_r == last_step);
  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

  always_comb begin
    case (job.kind)
      KIND_START: last_step = job.last ? 4'd9 : 4'd7;
      KIND_DATA:  last_step = job.last ? 4'd2 : 4'd0;
      default:    last_step = 4'd0;
    endcase
  end

  always_comb begin
    beat    = '0;
    covered = 1'b0;
    case (job.kind)
      KIND_START: begin
        case (step_r)
          4'd0: beat.out_byte = cfg.start_byte_one;
          4'd1: beat.out_byte = cfg.start_byte_two;
          4'd2: begin beat.out_byte = cfg.version_byte;  covered = 1'b1; end
          4'd3: begin beat.out_byte = job.frame_type;    covered = 1'b1; end
          4'd4: begin beat.out_byte = job.seq[7:0];      covered = 1'b1; end
          4'd5: begin beat.out_byte = job.seq[15:8];     covered = 1'b1; end
          4'd6: begin beat.out_byte = job.len[7:0];      covered = 1'b1; end
          4'd7: begin beat.out_byte = job.len[15:8];     covered = 1'b1; end
          4'd8: beat.out_byte = crc_r[7:0];
          4'd9: begin beat.out_byte = crc_r[15:8]; beat.frame_end = 1'b1; end
          default: beat = '0;
        endcase
      end
      KIND_DATA: begin
        case (step_r)
          4'd0: begin beat.out_byte = job.data; covered = 1'b1; end
          4'd1: beat.out_byte = crc_r[7:0];
          4'd2: begin beat.out_byte = crc_r[15:8]; beat.frame_end = 1'b1; end
          default: beat = '0;
        endcase
      end
      default: begin
        beat.frame_end = 1'b1;
        beat.error     = 1'b1;
      end
    endcase
  end

  // a new header restarts the CRC, which also drops an abandoned frame
  assign crc_base = ((job.kind == KIND_START) && (step_r == 4'd0)) ? CRC_INIT : crc_r;

  always_comb begin
    crc_nxt  = crc_r;
    step_nxt = step_r;
    if (advance) begin
      step_nxt = (step_r == last_step) ? 4'd0 : step_r + 4'd1;
      if (beat.frame_end) begin
        crc_nxt = CRC_INIT;
      end else if (covered) begin
        crc_nxt = crc_byte(crc_base, beat.out_byte);
      end else begin
        crc_nxt = crc_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 4'd0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      crc_r  <= crc_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= beat;
    end
  end

endmodule

// File: rtl/crc16_frame_builder_top.sv
// Top level: configuration registers and the front, queue and back ends.
//
//   channel | handshake         | payload
//   --------+-------------------+---------------------------------------
//   input   | push / full       | in_item  (command, header, data byte)
//   result  | empty / pop       | out_item (out_byte, frame_end, error)
//   config  | cfg_we            | cfg_index, cfg_data
//
// One input beat a cycle while the 4-entry job queue has room.
// The back end emits one byte a cycle unless pop holds it: 8 or 10 per start,
// 1 or 3 per payload byte, 1 per error; queued jobs feed a registered output.
// Synchronous active-low reset clears frame state, the queue and the output.
// pop low holds the output byte; the queue keeps taking input until it fills.
`timescale 1ns / 1ps
module crc16_frame_builder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  cfb_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output cfb_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import cfb_pkg::*;

  cfg_t cfg_r;
  job_t wr_job, rd_job;
  logic q_push, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte_one <= 8'h00;
      cfg_r.start_byte_two <= 8'h00;
      cfg_r.version_byte   <= 8'h01;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_ONE: cfg_r.start_byte_one <= cfg_data;
        REG_START_TWO: cfg_r.start_byte_two <= cfg_data;
        REG_VERSION:   cfg_r.version_byte   <= cfg_data;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  cfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .q_full  (full),
    .q_push  (q_push),
    .q_job   (wr_job)
  );

  cfb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_job  (wr_job),
    .rd_en   (q_pop),
    .rd_job  (rd_job),
    .q_full  (full),
    .q_empty (q_empty)
  );

  cfb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job      (rd_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// File: rtl/cfb_checker.sv
// Port-level checker for the frame builder, bound to the top level.
`timescale 1ns / 1ps
module cfb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input cfb_pkg::out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queue not clear after reset");

  a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.error) |-> out_item.frame_end)
    else $error("error beat without frame_end");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.error) |-> (out_item.out_byte == 8'h00))
    else $error("error beat carries a non-zero byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("stalled result beat changed");

endmodule

bind crc16_frame_builder_top cfb_checker u_cfb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

// File: bench/tb_crc16_frame_builder_top.sv
// Testbench for crc16_frame_builder_top: predicts the framed byte stream and checks each beat.
`timescale 1ns / 1ps
module tb_crc16_frame_builder_top;
  import cfb_pkg::*;

  localparam logic [1:0] REG_UNMAPPED  = 2'd3;
  localparam logic       CMD_START     = 1'b0;
  localparam logic       CMD_DATA      = 1'b1;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_PAD     = 24;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         RANDOM_ITEMS  = 330;
  localparam int         STREAM_ITEMS  = 60;
  localparam int         MAX_REPORTS   = 60;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       empty;
  logic       pop;
  out_item_t  out_item;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // predictor state and register copies
  logic [7:0]       marker_one;
  logic [7:0]       marker_two;
  logic [7:0]       version_id;
  logic [15:0]      crc_acc;
  logic [REM_W-1:0] bytes_left;
  logic             frame_live;

  out_item_t expected_bytes[$];
  int        fail_count;
  int        items_sent;
  bit        idling_enabled;
  int        hold_request;

  crc16_frame_builder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bit-serial form of the reflected MODBUS update
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic last, logic err);
    out_item_t r;
    r.out_byte  = b;
    r.frame_end = last;
    r.error     = err;
    expected_bytes.push_back(r);
  endfunction

  function automatic void emit_covered(logic [7:0] b);
    expect_byte(b, 1'b0, 1'b0);
    crc_acc = crc16_modbus_step(crc_acc, b);
  endfunction

  function automatic void close_frame();
    expect_byte(crc_acc[7:0], 1'b0, 1'b0);
    expect_byte(crc_acc[15:8], 1'b1, 1'b0);
    frame_live = 1'b0;
    bytes_left = '0;
    crc_acc    = CRC_INIT;
  endfunction

  function automatic void predict_frame_bytes(in_item_t it);
    if (it.command == CMD_START) begin
      // a new start drops whatever frame was open
      frame_live = 1'b0;
      bytes_left = '0;
      crc_acc    = CRC_INIT;
      if (it.data_len > MAX_PAYLOAD) begin
        expect_byte(8'h00, 1'b1, 1'b1);
      end else begin
        expect_byte(marker_one, 1'b0, 1'b0);
        expect_byte(marker_two, 1'b0, 1'b0);
        emit_covered(version_id);
        emit_covered(it.frame_type);
        emit_covered(it.sequence_number[7:0]);
        emit_covered(it.sequence_number[15:8]);
        emit_covered(it.data_len[7:0]);
        emit_covered(it.data_len[15:8]);
        if (it.data_len == 16'd0) begin
          close_frame();
        end else begin
          frame_live = 1'b1;
          bytes_left = it.data_len[REM_W-1:0];
        end
      end
    end else if (!frame_live || bytes_left == '0) begin
      expect_byte(8'h00, 1'b1, 1'b1);
    end else begin
      emit_covered(it.data_byte);
      bytes_left = bytes_left - REM_W'(1);
      if (bytes_left == '0) begin
        close_frame();
      end
    end
  endfunction

  function automatic in_item_t any_item();
    in_item_t it;
    it.command         = 1'($urandom);
    it.frame_type      = 8'($urandom);
    it.sequence_number = 16'($urandom);
    it.data_len        = 16'($urandom);
    it.data_byte       = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t start_item(logic [15:0] len);
    in_item_t it;
    it          = any_item();
    it.command  = CMD_START;
    it.data_len = len;
    return it;
  endfunction

  function automatic in_item_t data_item(logic [7:0] b);
    in_item_t it;
    it           = any_item();
    it.command   = CMD_DATA;
    it.data_byte = b;
    return it;
  endfunction

  // biased towards the register extremes
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      return 8'h00;
    end else if (sel == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  // push stays high on return so back-to-back beats need no second assignment
  task automatic push_beat(in_item_t it);
    @(negedge clk);
    push    <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk);
    end while (full !== 1'b0);
    predict_frame_bytes(it);
    items_sent++;
  endtask

  task automatic sender_gap(int n);
    @(negedge clk);
    push    <= 1'b0;
    in_item <= any_item();
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (idling_enabled && $urandom_range(0, 4) == 0) begin
      sender_gap($urandom_range(1, 12));
    end
  endtask

  // sender pauses until every predicted beat has been taken
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_ONE: marker_one = val;
      REG_START_TWO: marker_two = val;
      REG_VERSION:   version_id = val;
      default: ;
    endcase
  endtask

  task automatic program_config(logic [7:0] one, logic [7:0] two, logic [7:0] ver);
    write_reg(REG_START_ONE, one);
    write_reg(REG_START_TWO, two);
    write_reg(REG_VERSION, ver);
  endtask

  task automatic send_frame(int len, int payload_sent);
    push_beat(start_item(len[15:0]));
    for (int i = 0; i < payload_sent; i++) begin
      if (idling_enabled && $urandom_range(0, 49) == 0) begin
        settle();
      end else begin
        maybe_gap();
      end
      push_beat(data_item(8'($urandom)));
    end
  endtask

  task automatic test_reset_values();
    in_item_t it;
    it                 = start_item(16'd2);
    it.frame_type      = 8'hA5;
    it.sequence_number = 16'h1234;
    push_beat(it);
    push_beat(data_item(8'h00));
    push_beat(data_item(8'hFF));
    settle();
  endtask

  task automatic test_config_extremes();
    in_item_t it;
    program_config(8'hFF, 8'hFF, 8'hFF);
    it                 = start_item(16'd0);
    it.frame_type      = 8'hFF;
    it.sequence_number = 16'hFFFF;
    push_beat(it);
    settle();
    program_config(8'h00, 8'h00, 8'h00);
    it                 = start_item(16'd0);
    it.frame_type      = 8'h00;
    it.sequence_number = 16'h0000;
    push_beat(it);
    settle();
    // out-of-range index must leave every register alone
    write_reg(REG_UNMAPPED, 8'($urandom));
    push_beat(start_item(16'd1));
    push_beat(data_item(8'h5A));
    settle();
  endtask

  task automatic test_special_cases();
    program_config(8'h55, 8'hAA, 8'h02);
    push_beat(data_item(8'($urandom)));
    push_beat(start_item(16'(MAX_PAYLOAD + 1)));
    push_beat(start_item(16'hFFFF));
    // frame dropped part way by a fresh start
    push_beat(start_item(16'd3));
    push_beat(data_item(8'h11));
    push_beat(start_item(16'd1));
    push_beat(data_item(8'h22));
    push_beat(data_item(8'h33));
    // oversized start drops the open frame
    push_beat(start_item(16'd2));
    push_beat(start_item(16'h8000));
    push_beat(data_item(8'h44));
    settle();
  endtask

  task automatic test_max_length();
    send_frame(MAX_PAYLOAD, MAX_PAYLOAD);
    settle();
  endtask

  task automatic test_backpressure();
    idling_enabled = 1'b0;
    hold_request   = HOLD_CYCLES;
    repeat (3) send_frame(4, 4);
    settle();
    idling_enabled = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    int pick;
    int len;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        idling_enabled = !idling_enabled;
      end
      if ($urandom_range(0, 24) == 0) begin
        settle();
        program_config(pick_byte(), pick_byte(), pick_byte());
        if ($urandom_range(0, 3) == 0) begin
          write_reg(REG_UNMAPPED, 8'($urandom));
        end
      end
      pick = $urandom_range(0, 19);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_PAYLOAD) : $urandom_range(0, 8);
      if (pick < 15) begin
        send_frame(len, len);
      end else if (pick < 17) begin
        send_frame(len, $urandom_range(0, len));
      end else if (pick < 18) begin
        push_beat(data_item(8'($urandom)));
      end else begin
        push_beat(start_item(16'($urandom_range(MAX_PAYLOAD + 1, 65535))));
      end
      maybe_gap();
    end
  endtask

  task automatic test_streaming();
    int target;
    idling_enabled = 1'b0;
    settle();
    program_config(pick_byte(), pick_byte(), pick_byte());
    target = items_sent + STREAM_ITEMS;
    while (items_sent < target) begin
      send_frame($urandom_range(0, 8), $urandom_range(0, 8));
    end
  endtask

  // result side: random stalls, long hold on request, one check per beat
  initial begin : result_sink
    int        stall_left;
    int        hold_left;
    out_item_t want;
    stall_left = 0;
    hold_left  = 0;
    pop        = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (idling_enabled && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && empty === 1'b0) begin
        if (expected_bytes.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $display("%0t: unexpected beat byte %02h end %0b err %0b", $time,
                     out_item.out_byte, out_item.frame_end, out_item.error);
          end
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            if (fail_count < MAX_REPORTS) begin
              $display("%0t: out_byte expected %02h actual %02h", $time,
                       want.out_byte, out_item.out_byte);
            end
            fail_count++;
          end
          if (out_item.frame_end !== want.frame_end) begin
            if (fail_count < MAX_REPORTS) begin
              $display("%0t: frame_end expected %0b actual %0b", $time,
                       want.frame_end, out_item.frame_end);
            end
            fail_count++;
          end
          if (out_item.error !== want.error) begin
            if (fail_count < MAX_REPORTS) begin
              $display("%0t: error expected %0b actual %0b", $time,
                       want.error, out_item.error);
            end
            fail_count++;
          end
        end
      end
    end
  end

  // cycles with no beat on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[crc16_frame_builder_top] ERROR");
    $finish;
  end

  initial begin
    push           = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_START_ONE;
    cfg_data       = 8'h00;
    rst_n          = 1'b0;
    fail_count     = 0;
    items_sent     = 0;
    idling_enabled = 1'b1;
    hold_request   = 0;
    marker_one     = 8'h00;
    marker_two     = 8'h00;
    version_id     = 8'h01;
    crc_acc        = CRC_INIT;
    bytes_left     = '0;
    frame_live     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_config_extremes();
    test_special_cases();
    test_max_length();
    test_backpressure();
    test_random_traffic();
    test_streaming();
    settle();

    if (fail_count == 0) begin
      $display("[crc16_frame_builder_top] OK");
    end else begin
      $display("[crc16_frame_builder_top] ERROR");
    end
    $finish;
  end

endmodule

// File: crc16_frame_builder_top.f
rtl/cfb_pkg.sv
rtl/cfb_front.sv
rtl/cfb_queue.sv
rtl/cfb_back.sv
rtl/crc16_frame_builder_top.sv
rtl/cfb_checker.sv
bench/tb_crc16_frame_builder_top.sv
